FILE: rtl/core/interval_lane_assigner_defines.svh
// assertion helpers shared by the lane assigner rtl
`ifndef INTERVAL_LANE_ASSIGNER_DEFINES_SVH
`define INTERVAL_LANE_ASSIGNER_DEFINES_SVH

// same-cycle implication, inactive while reset is held
`define ILA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive while reset is held
`define ILA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ila_pkg.sv
package ila_pkg;

    localparam int MINUTE_W = 11;
    localparam int LANE_W = 6;
    localparam int IDX_W = 6;

    localparam logic [LANE_W-1:0] LANES_RESET = 6'd32;
    localparam logic [LANE_W-1:0] LANE_CAP = 6'd63;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW = 2;

    // one classified interval, handed from the front to the back
    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic              close_prev;
        logic [LANE_W-1:0] close_peak;
        logic [LANE_W-1:0] cur_peak;
        logic              last;
    } t_cmd;

endpackage

FILE: rtl/core/ila_channels.sv
interface ila_in_if import ila_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MINUTE_W-1:0] span_start;
    logic [MINUTE_W-1:0] span_end;
    logic                last_event;

    modport source(output valid, output span_start, output span_end,
                   output last_event, input ready);
    modport sink(input valid, input span_start, input span_end,
                 input last_event, output ready);
endinterface

interface ila_out_if import ila_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  event_index;
    logic [LANE_W-1:0] lane;
    logic [LANE_W-1:0] lane_total;
    logic              last_of_run;

    modport source(output valid, output event_index, output lane, output lane_total,
                   output last_of_run, input ready);
    modport sink(input valid, input event_index, input lane, input lane_total,
                 input last_of_run, output ready);
endinterface

FILE: rtl/core/ila_front.sv
module ila_front import ila_pkg::*; #(
    parameter int ACTIVE_SLOTS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ila_in_if.sink            i_in,
    input  logic [LANE_W-1:0] i_max_lanes,
    input  logic              i_q_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    localparam int SAW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
    localparam int CNT_W = $clog2(ACTIVE_SLOTS + 1);
    localparam int NGRP = (ACTIVE_SLOTS + 7) / 8;

    typedef enum logic [1:0] {F_IDLE, F_DROP, F_FIND, F_PUSH} t_fstate;

    t_fstate r_state;

    logic [ACTIVE_SLOTS-1:0] r_valid;
    logic [ACTIVE_SLOTS-1:0] n_valid;
    logic [MINUTE_W-1:0]     r_end [ACTIVE_SLOTS];
    logic [LANE_W-1:0]       r_alane [ACTIVE_SLOTS];

    logic [MINUTE_W-1:0] r_s;
    logic [MINUTE_W-1:0] r_e;
    logic                r_last;

    logic [LANE_W-1:0] r_lane;
    logic [LANE_W-1:0] n_lane;
    logic [SAW-1:0]    r_slot;
    logic [SAW-1:0]    n_slot;
    logic              r_has_free;
    logic              n_has_free;
    logic [3:0]        r_grp [NGRP];
    logic [3:0]        n_grp [NGRP];

    logic                r_open;
    logic [MINUTE_W-1:0] r_cend;
    logic [MINUTE_W-1:0] n_cend;
    logic [CNT_W-1:0]    r_peak;
    logic [CNT_W-1:0]    n_peak;

    logic [ACTIVE_SLOTS-1:0] used;
    logic [6:0]              limit;
    logic [CNT_W-1:0]        count;
    logic [CNT_W-1:0]        here;
    logic                    close;
    logic                    push_go;

    function automatic logic [LANE_W-1:0] cap_peak(input logic [CNT_W-1:0] v);
        logic [6:0] w;
        w = 7'(v);
        return (w > 7'(LANE_CAP)) ? LANE_CAP : w[LANE_W-1:0];
    endfunction

    assign i_in.ready = (r_state == F_IDLE);
    assign push_go = (r_state == F_PUSH) && !i_q_full;

    // lane search, free slot and per-group occupancy over the surviving set
    always_comb begin
        limit = (7'(i_max_lanes) > 7'(ACTIVE_SLOTS)) ? 7'(ACTIVE_SLOTS) : 7'(i_max_lanes);
        used = '0;
        for (int l = 0; l < ACTIVE_SLOTS; l++) begin
            for (int j = 0; j < ACTIVE_SLOTS; j++) begin
                if (r_valid[j] && (r_alane[j] == LANE_W'(l))) begin
                    used[l] = 1'b1;
                end
            end
        end
        n_lane = limit[LANE_W-1:0];
        for (int l = ACTIVE_SLOTS - 1; l >= 0; l--) begin
            if ((7'(l) < limit) && !used[l]) begin
                n_lane = LANE_W'(l);
            end
        end
        n_has_free = 1'b0;
        n_slot = '0;
        for (int j = ACTIVE_SLOTS - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                n_has_free = 1'b1;
                n_slot = SAW'(j);
            end
        end
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (g * 8 + b < ACTIVE_SLOTS) begin
                    if (r_valid[g * 8 + b]) begin
                        n_grp[g] = n_grp[g] + 4'd1;
                    end
                end
            end
        end
    end

    // cluster bookkeeping, expiry of ended slots and slot insertion
    always_comb begin
        count = '0;
        for (int g = 0; g < NGRP; g++) begin
            count = count + CNT_W'(r_grp[g]);
        end
        here = count + CNT_W'(r_has_free);
        close = r_open && !(r_s < r_cend);
        if (!r_open || close) begin
            n_cend = r_e;
            n_peak = here;
        end else begin
            n_cend = (r_e > r_cend) ? r_e : r_cend;
            n_peak = (here > r_peak) ? here : r_peak;
        end

        n_valid = r_valid;
        if (r_state == F_DROP) begin
            for (int j = 0; j < ACTIVE_SLOTS; j++) begin
                n_valid[j] = r_valid[j] && (r_end[j] > r_s);
            end
        end else if (push_go) begin
            if (r_last) begin
                n_valid = '0;
            end else begin
                for (int j = 0; j < ACTIVE_SLOTS; j++) begin
                    if (r_has_free && (SAW'(j) == r_slot)) begin
                        n_valid[j] = 1'b1;
                    end
                end
            end
        end
    end

    assign o_push = push_go;
    assign o_cmd.lane = r_lane;
    assign o_cmd.close_prev = close;
    assign o_cmd.close_peak = cap_peak(r_peak);
    assign o_cmd.cur_peak = cap_peak(n_peak);
    assign o_cmd.last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_valid <= '0;
            r_open <= 1'b0;
            r_cend <= '0;
            r_peak <= CNT_W'(1);
        end else begin
            r_valid <= n_valid;
            unique case (r_state)
                F_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= F_DROP;
                    end
                end
                F_DROP: begin
                    r_state <= F_FIND;
                end
                F_FIND: begin
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                        if (r_last) begin
                            r_open <= 1'b0;
                            r_cend <= '0;
                            r_peak <= CNT_W'(1);
                        end else begin
                            r_open <= 1'b1;
                            r_cend <= n_cend;
                            r_peak <= n_peak;
                        end
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == F_IDLE) && i_in.valid) begin
            r_s <= i_in.span_start;
            r_e <= i_in.span_end;
            r_last <= i_in.last_event;
        end
        if (r_state == F_FIND) begin
            r_lane <= n_lane;
            r_slot <= n_slot;
            r_has_free <= n_has_free;
            r_grp <= n_grp;
        end
        if (push_go && r_has_free) begin
            r_end[r_slot] <= r_e;
            r_alane[r_slot] <= r_lane;
        end
    end

endmodule

FILE: rtl/core/ila_cmd_queue.sv
`include "interval_lane_assigner_defines.svh"

module ila_cmd_queue import ila_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd                r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  r_wptr;
    logic [CMDQ_AW-1:0]  r_rptr;
    logic [CMDQ_AW:0]    r_cnt;

    assign o_full = (r_cnt == (CMDQ_AW + 1)'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10: r_cnt <= r_cnt + 1'b1;
                2'b01: r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    `ILA_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt < (CMDQ_AW + 1)'(CMDQ_DEPTH) || i_pop, "transaction pushed into a full command queue")
    `ILA_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from an empty command queue")
    `ILA_ASSERT_NXT(a_push_visible, i_clk, i_rst_n, i_push, o_valid, "pushed transaction not held")

endmodule

FILE: rtl/core/ila_back.sv
`include "interval_lane_assigner_defines.svh"

module ila_back import ila_pkg::*; #(
    parameter int MAX_EVENTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_pop,
    ila_out_if.source o_out
);

    localparam int PCNT_W = $clog2(MAX_EVENTS + 1);
    localparam int PAW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam bit ONE_EVENT = (MAX_EVENTS == 1);

    typedef enum logic [1:0] {B_IDLE, B_APPEND, B_RD, B_EMIT} t_bstate;

    t_bstate r_state;

    logic [LANE_W-1:0] r_pend [MAX_EVENTS];
    logic [LANE_W-1:0] r_rd_lane;

    t_cmd              r_cmd;
    logic [PCNT_W-1:0] r_pcount;
    logic [PCNT_W-1:0] r_k;
    logic [IDX_W-1:0]  r_first;
    logic [IDX_W-1:0]  r_batch;
    logic              r_phase_close;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_index;
    logic [LANE_W-1:0] r_out_lane;
    logic [LANE_W-1:0] r_out_count;
    logic              r_out_last;

    logic slot_free;
    logic emit_go;
    logic final_one;
    logic run_end;

    assign slot_free = !r_out_valid || o_out.ready;
    assign emit_go = (r_state == B_EMIT) && slot_free;
    assign final_one = ((r_k + 1'b1) == r_pcount);
    // a close flush is followed by a second flush when the batch ends or the buffer holds one event
    assign run_end = final_one && (!r_phase_close || !(r_cmd.last || ONE_EVENT));
    assign o_pop = (r_state == B_IDLE) && i_q_valid;

    assign o_out.valid = r_out_valid;
    assign o_out.event_index = r_out_index;
    assign o_out.lane = r_out_lane;
    assign o_out.lane_total = r_out_count;
    assign o_out.last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_pcount <= '0;
            r_k <= '0;
            r_first <= '0;
            r_batch <= '0;
            r_phase_close <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_cmd.close_prev && (r_pcount != '0)) begin
                            r_phase_close <= 1'b1;
                            r_k <= '0;
                            r_state <= B_RD;
                        end else begin
                            r_state <= B_APPEND;
                        end
                    end
                end
                B_APPEND: begin
                    if (r_pcount == '0) begin
                        r_first <= r_batch;
                    end
                    r_pcount <= r_pcount + 1'b1;
                    r_batch <= r_batch + 1'b1;
                    if (r_cmd.last || (r_pcount == PCNT_W'(MAX_EVENTS - 1))) begin
                        r_phase_close <= 1'b0;
                        r_k <= '0;
                        r_state <= B_RD;
                    end else begin
                        r_state <= B_IDLE;
                    end
                end
                B_RD: begin
                    r_state <= B_EMIT;
                end
                B_EMIT: begin
                    if (slot_free) begin
                        if (final_one) begin
                            r_pcount <= '0;
                            if (r_phase_close) begin
                                r_state <= B_APPEND;
                            end else begin
                                if (r_cmd.last) begin
                                    r_batch <= '0;
                                    r_first <= '0;
                                end
                                r_state <= B_IDLE;
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_state <= B_RD;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (emit_go) begin
            r_out_index <= r_first + IDX_W'(r_k);
            r_out_lane <= r_rd_lane;
            r_out_count <= r_phase_close ? r_cmd.close_peak : r_cmd.cur_peak;
            r_out_last <= run_end;
        end
    end

    // pending lane buffer
    always_ff @(posedge i_clk) begin
        if (r_state == B_APPEND) begin
            r_pend[r_pcount[PAW-1:0]] <= r_cmd.lane;
        end
        if (r_state == B_RD) begin
            r_rd_lane <= r_pend[r_k[PAW-1:0]];
        end
    end

    `ILA_ASSERT_IMP(a_flush_in_range, i_clk, i_rst_n, r_state == B_EMIT, r_k < r_pcount, "flush position beyond pending count")
    `ILA_ASSERT_IMP(a_pending_bound, i_clk, i_rst_n, 1'b1, r_pcount <= PCNT_W'(MAX_EVENTS), "pending count beyond buffer depth")
    `ILA_ASSERT_NXT(a_last_flushes, i_clk, i_rst_n, r_state == B_APPEND && r_cmd.last, r_state == B_RD, "batch end did not start a flush")

endmodule

FILE: rtl/core/interval_lane_assigner.sv
// Greedy lane assignment for a batch of intervals sorted by start, one interval
// per input transaction. The front handles one interval at a time: accept,
// expire the active intervals that end at or before the new start, search the
// lowest free lane, then insert and classify against the open cluster. The
// classified interval goes through a 4-entry command queue to the back, which
// parks lanes in a MAX_EVENTS-deep buffer and, when a cluster closes, the
// buffer fills or the batch ends, emits them one result at a time (buffer
// read, then output register). A long flush holds the back, so the front
// stalls once the command queue is full. No clearing pass after reset.
module interval_lane_assigner import ila_pkg::*; #(
    parameter int ACTIVE_SLOTS = 32,
    parameter int MAX_EVENTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ila_in_if.sink            i_in,
    ila_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [LANE_W-1:0] i_cfg_wdata
);

    logic [LANE_W-1:0] r_max_lanes;

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lanes <= LANES_RESET;
        end else if (i_cfg_we) begin
            r_max_lanes <= i_cfg_wdata;
        end
    end

    ila_front #(
        .ACTIVE_SLOTS(ACTIVE_SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_max_lanes (r_max_lanes),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    ila_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    ila_back #(
        .MAX_EVENTS(MAX_EVENTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
